[sv/wbc_pkg.sv]
// Types, constants and helpers for the wide BVH collapse cost block.
package wbc_pkg;

  localparam int NODE_COUNT = 4096;             // power of two
  localparam int WAYS_M1    = 7;
  localparam int COST_W     = 48;
  localparam int AW         = $clog2(NODE_COUNT);
  localparam int KW         = $clog2(WAYS_M1);
  localparam int PROD_W     = ((COST_W > 35) ? COST_W : 35) + 1;

  localparam logic [COST_W-1:0]  COST_INF   = '1;
  localparam logic signed [3:0]  SHARE_NONE = -4'sd1;

  typedef enum logic [1:0] {
    KIND_LEAF     = 2'd0,
    KIND_INTERNAL = 2'd1,
    KIND_DIST     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM0,
    ST_FIN0,
    ST_SUMS,
    ST_WB,
    ST_OUT
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [COST_W-1:0]  cost;
    logic signed [3:0]  lsh;
    logic signed [3:0]  rsh;
  } entry_t;

  typedef entry_t [WAYS_M1-1:0] row_t;

  typedef struct packed {
    logic [11:0] node_id;
    logic [11:0] first_child;
    logic        is_leaf;
    logic [31:0] half_area;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         slot;
    kind_t              kind;
    logic [COST_W-1:0]  cost;
    logic signed [3:0]  left_share;
    logic signed [3:0]  right_share;
    logic [2:0]         subtree_prims;
    logic               last;
  } out_word_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_INF : s[COST_W-1:0];
  endfunction

endpackage

[sv/wide_bvh_collapse_cost_dp.sv]
// Wide BVH collapse cost table: per-node decision entries held in row memory.
//
//  port group   dir   handshake          payload
//  in_*         in    in_valid/in_stall  in_word (in_word_t)
//  out_*        out   out_valid/out_stall out_word (out_word_t)
//  cfg_*        in    cfg_we             cfg_wdata (max leaf prims)
//
// A leaf node loads, writes back, sends 7 words, one per unstalled cycle.
// An internal node loads, then one shared saturating adder and compare walks
// all 28 child cost pairs, one pair a cycle, plus a row write-back; the 7
// output words follow. Next item is taken once all are out.
// Reset clears the state and sets max leaf prims to 3; table rows are undefined until written.
// Output stall holds the current word and the whole block.
module wide_bvh_collapse_cost_dp import wbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic [1:0] cfg_wdata
);

  row_t       dec_mem [NODE_COUNT];
  logic [2:0] prim_mem [NODE_COUNT];

  state_t            state_r, state_nxt;
  in_word_t          item_r;
  row_t              rd_l_r, rd_r_r;
  logic [2:0]        pl_r, pr_r;
  logic [2:0]        prims_r;
  logic [1:0]        max_leaf_r;
  logic [KW-1:0]     k_r, s_r, bl_r;
  logic              won_r;
  logic [COST_W-1:0] best_r;
  entry_t            e_r [WAYS_M1];

  logic              accept_in, accept_out;
  logic [AW-1:0]     lc_addr, rc_addr, wr_addr;
  logic [12:0]       fc1;
  logic [KW-1:0]     r_idx, bl_new, s_m1;
  logic [COST_W-1:0] cand, best_new, leaf_cost, internal;
  logic              better, won_new, leaf_lt, leaf_ok;
  logic [PROD_W-1:0] prod;
  logic [3:0]        psum;
  row_t              row_w;

  assign accept_in  = in_valid & ~in_stall;
  assign accept_out = out_valid & ~out_stall;

  assign fc1     = {1'b0, in_word.first_child} + 13'd1;
  assign lc_addr = AW'(in_word.first_child % NODE_COUNT);
  assign rc_addr = AW'(fc1 % NODE_COUNT);
  assign wr_addr = AW'(item_r.node_id % NODE_COUNT);

  always_comb begin
    for (int i = 0; i < WAYS_M1; i++) row_w[i] = e_r[i];
  end

  // Table memories: two child reads at accept, one row write per node.
  always_ff @(posedge clk) begin
    if (state_r == ST_WB) begin
      dec_mem[wr_addr]  <= row_w;
      prim_mem[wr_addr] <= prims_r;
    end
    if (accept_in) begin
      rd_l_r <= dec_mem[lc_addr];
      rd_r_r <= dec_mem[rc_addr];
      pl_r   <= prim_mem[lc_addr];
      pr_r   <= prim_mem[rc_addr];
    end
  end

  // Shared pair adder and compare.
  assign s_m1     = s_r - KW'(1);
  assign r_idx    = (state_r == ST_SUM0) ? (KW'(WAYS_M1 - 1) - k_r) : (s_m1 - k_r);
  assign cand     = sat_add(rd_l_r[k_r].cost, rd_r_r[r_idx].cost);
  assign better   = cand < best_r;
  assign best_new = better ? cand : best_r;
  assign won_new  = won_r | better;
  assign bl_new   = better ? k_r : bl_r;

  assign psum      = {1'b0, pl_r} + {1'b0, pr_r};
  assign prod      = PROD_W'(prims_r) * PROD_W'(item_r.half_area);
  assign leaf_ok   = prims_r <= {1'b0, max_leaf_r};
  assign leaf_cost = (!leaf_ok || prod > PROD_W'(COST_INF)) ? COST_INF : COST_W'(prod);
  assign internal  = sat_add(best_r, COST_W'(item_r.half_area));
  assign leaf_lt   = leaf_cost < internal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_leaf_r <= 2'd3;
    end else if (cfg_we) begin
      max_leaf_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept_in) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = item_r.is_leaf ? ST_WB : ST_SUM0;
      ST_SUM0: if (k_r == KW'(WAYS_M1 - 1)) state_nxt = ST_FIN0;
      ST_FIN0: state_nxt = ST_SUMS;
      ST_SUMS: if (k_r == s_m1 && s_r == KW'(WAYS_M1 - 1)) state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_OUT;
      ST_OUT:  if (accept_out && k_r == KW'(WAYS_M1 - 1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept_in) item_r <= in_word;
      end
      ST_LOAD: begin
        k_r    <= '0;
        best_r <= COST_INF;
        won_r  <= 1'b0;
        bl_r   <= '0;
        if (item_r.is_leaf) begin
          prims_r <= 3'd1;
          for (int i = 0; i < WAYS_M1; i++) begin
            e_r[i] <= '{KIND_LEAF, COST_W'(item_r.half_area), SHARE_NONE, SHARE_NONE};
          end
        end else begin
          prims_r <= (psum > 4'd7) ? 3'd7 : psum[2:0];
        end
      end
      ST_SUM0: begin
        best_r <= best_new;
        won_r  <= won_new;
        bl_r   <= bl_new;
        k_r    <= k_r + KW'(1);
      end
      ST_FIN0: begin
        e_r[0].kind <= leaf_lt ? KIND_LEAF : KIND_INTERNAL;
        e_r[0].cost <= leaf_lt ? leaf_cost : internal;
        e_r[0].lsh  <= won_r ? $signed(4'(bl_r)) : SHARE_NONE;
        e_r[0].rsh  <= won_r ? $signed(4'(KW'(WAYS_M1 - 1) - bl_r)) : SHARE_NONE;
        best_r      <= leaf_lt ? leaf_cost : internal;
        won_r       <= 1'b0;
        s_r         <= KW'(1);
        k_r         <= '0;
      end
      ST_SUMS: begin
        if (k_r == s_m1) begin
          // close this slot: new split or copy of the previous slot
          if (won_new) begin
            e_r[s_r] <= '{KIND_DIST, best_new, $signed(4'(bl_new)),
                          $signed(4'(s_m1 - bl_new))};
          end else begin
            e_r[s_r] <= e_r[s_m1];
          end
          best_r <= best_new;
          won_r  <= 1'b0;
          s_r    <= s_r + KW'(1);
          k_r    <= '0;
        end else begin
          best_r <= best_new;
          won_r  <= won_new;
          bl_r   <= bl_new;
          k_r    <= k_r + KW'(1);
        end
      end
      ST_WB: begin
        k_r <= '0;
      end
      ST_OUT: begin
        if (accept_out) k_r <= k_r + KW'(1);
      end
      default: begin
        k_r <= '0;
      end
    endcase
  end

  always_comb begin
    out_word.slot          = 3'(k_r);
    out_word.kind          = e_r[k_r].kind;
    out_word.cost          = e_r[k_r].cost;
    out_word.left_share    = e_r[k_r].lsh;
    out_word.right_share   = e_r[k_r].rsh;
    out_word.subtree_prims = prims_r;
    out_word.last          = (k_r == KW'(WAYS_M1 - 1));
  end

endmodule
